// ----- rtl/sads_pkg.sv -----
// sads_pkg: shared types, constants and helpers of the subarray delay-and-sum core
// no dependencies; used by every rtl file except sads_ram through scoped names
`default_nettype none

package sads_pkg;

    // history depth must be a power of two so that slot arithmetic wraps
    localparam int HISTORY_DEPTH = 64;
    localparam int SLOT_BITS     = $clog2(HISTORY_DEPTH);
    localparam int MIC_COUNT     = 7;
    localparam int SAMPLE_BITS   = 16;
    localparam int DELAY_BITS    = 6;
    localparam int LAG_CENTER    = 31;
    localparam int LAG_W         = (SLOT_BITS > DELAY_BITS) ? SLOT_BITS : DELAY_BITS;
    localparam int SUB_COUNT     = 3;
    localparam int TAPS          = 3;
    localparam int REG_COUNT     = 6;
    localparam int CFG_IDX_W     = $clog2(REG_COUNT);

    localparam int SUM_W         = SAMPLE_BITS + 2;
    localparam int THIRD_W       = 17;
    localparam int THIRD_NUM     = 21845;
    localparam int THIRD_SHIFT   = 16;
    localparam int PROD_W        = SUM_W + THIRD_W;

    localparam int Q_DEPTH       = 8;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    // microphones of each subarray, first one undelayed
    localparam int SUB_MICS [SUB_COUNT][TAPS] = '{'{0, 3, 6}, '{1, 3, 5}, '{2, 3, 4}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUB1_MID = 3'd0,
        REG_SUB1_FAR = 3'd1,
        REG_SUB2_MID = 3'd2,
        REG_SUB2_FAR = 3'd3,
        REG_SUB3_MID = 3'd4,
        REG_SUB3_FAR = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mic0_sample;
        logic signed [SAMPLE_BITS-1:0] mic1_sample;
        logic signed [SAMPLE_BITS-1:0] mic2_sample;
        logic signed [SAMPLE_BITS-1:0] mic3_sample;
        logic signed [SAMPLE_BITS-1:0] mic4_sample;
        logic signed [SAMPLE_BITS-1:0] mic5_sample;
        logic signed [SAMPLE_BITS-1:0] mic6_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sub1_out;
        logic signed [SAMPLE_BITS-1:0] sub2_out;
        logic signed [SAMPLE_BITS-1:0] sub3_out;
    } t_out_item;

    typedef struct packed {
        logic                 acc;
        logic [SLOT_BITS-1:0] slot;
    } t_lane_ctl;

    typedef struct packed {
        logic                          vld;
        logic signed [SAMPLE_BITS-1:0] avg;
    } t_lane_res;

    typedef logic [TAPS-1:0][SAMPLE_BITS-1:0] t_tap_samples;
    typedef logic [TAPS-1:0][DELAY_BITS-1:0]  t_tap_delays;

    // read offset behind the write slot: (31 - delay) mod depth
    function automatic logic [SLOT_BITS-1:0] lag_offset(input logic [DELAY_BITS-1:0] delay);
        logic [DELAY_BITS-1:0] lag;
        logic [LAG_W-1:0]      wide;
        lag  = DELAY_BITS'(LAG_CENTER) - delay;
        wide = LAG_W'(lag);
        return wide[SLOT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sads_ram.sv -----
// sads_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module sads_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sads_lane.sv -----
// sads_lane: one subarray lane, three tap histories, delayed read, sum and divide by three
// depends on sads_pkg and sads_ram
`default_nettype none

module sads_lane (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire sads_pkg::t_lane_ctl                 i_ctl,
    input  wire logic [sads_pkg::HISTORY_DEPTH-1:0]  i_slot_vld,
    input  wire sads_pkg::t_tap_samples              i_samp,
    input  wire sads_pkg::t_tap_delays               i_delay,
    output sads_pkg::t_lane_res                      o_res
);

    localparam int SB = sads_pkg::SAMPLE_BITS;
    localparam int TP = sads_pkg::TAPS;

    localparam logic signed [sads_pkg::THIRD_W-1:0] THIRD_K =
        sads_pkg::THIRD_W'(sads_pkg::THIRD_NUM);

    logic [TP-1:0][sads_pkg::SLOT_BITS-1:0] w_off;
    logic [TP-1:0][sads_pkg::SLOT_BITS-1:0] w_rd_addr;
    logic [TP-1:0][SB-1:0]                  w_rd_data;
    logic [TP-1:0][SB-1:0]                  w_tap;

    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    logic [TP-1:0]         r_byp;
    logic [TP-1:0]         r_live;
    logic [TP-1:0][SB-1:0] r_byp_data;

    logic signed [sads_pkg::SUM_W-1:0]  n_sum;
    logic signed [sads_pkg::SUM_W-1:0]  r_sum;
    logic signed [sads_pkg::PROD_W-1:0] r_prod;

    for (genvar t = 0; t < TP; t++) begin : g_tap
        assign w_off[t]     = sads_pkg::lag_offset(i_delay[t]);
        assign w_rd_addr[t] = i_ctl.slot - w_off[t];

        sads_ram #(
            .WIDTH (SB),
            .DEPTH (sads_pkg::HISTORY_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (i_ctl.acc),
            .i_wr_addr (i_ctl.slot),
            .i_wr_data (i_samp[t]),
            .i_rd_en   (i_ctl.acc),
            .i_rd_addr (w_rd_addr[t]),
            .o_rd_data (w_rd_data[t])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // lag zero reads the sample being written this cycle
    always_ff @(posedge i_clk) begin
        for (int t = 0; t < TP; t++) begin
            r_byp[t]      <= (w_off[t] == '0);
            r_live[t]     <= i_slot_vld[w_rd_addr[t]];
            r_byp_data[t] <= i_samp[t];
        end
        r_sum  <= n_sum;
        r_prod <= sads_pkg::PROD_W'(r_sum) * sads_pkg::PROD_W'(THIRD_K);
    end

    always_comb begin
        for (int t = 0; t < TP; t++) begin
            if (r_byp[t]) begin
                w_tap[t] = r_byp_data[t];
            end else if (r_live[t]) begin
                w_tap[t] = w_rd_data[t];
            end else begin
                w_tap[t] = '0;
            end
        end
        n_sum = sads_pkg::SUM_W'(signed'(w_tap[0]))
              + sads_pkg::SUM_W'(signed'(w_tap[1]))
              + sads_pkg::SUM_W'(signed'(w_tap[2]));
    end

    assign o_res.vld = r_v3;
    assign o_res.avg = r_prod[sads_pkg::THIRD_SHIFT +: SB];

endmodule

`default_nettype wire

// ----- rtl/sads_merge.sv -----
// sads_merge: joins the three lane results into one output item and queues it
// depends on sads_pkg; tracks items in flight so the queue never overflows
`default_nettype none

module sads_merge (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_acc,
    input  wire sads_pkg::t_lane_res  i_res [sads_pkg::SUB_COUNT],
    input  wire logic                 i_stall,
    output logic                      o_full,
    output logic                      o_valid,
    output sads_pkg::t_out_item       o_item
);

    localparam int CW = sads_pkg::Q_CNT_W;

    sads_pkg::t_out_item r_q [sads_pkg::Q_DEPTH];
    sads_pkg::t_out_item w_item;

    logic [sads_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [sads_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                r_occ;
    logic                         w_push;
    logic                         w_pop;

    assign w_push = i_res[0].vld & i_res[1].vld & i_res[2].vld;
    assign w_pop  = o_valid & ~i_stall;

    assign w_item.sub1_out = i_res[0].avg;
    assign w_item.sub2_out = i_res[1].avg;
    assign w_item.sub3_out = i_res[2].avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_occ    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
            r_occ <= r_occ + CW'(i_acc) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    assign o_full  = (r_occ == CW'(sads_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rd_ptr];

endmodule

`default_nettype wire

// ----- rtl/subarray_delay_and_sum_core.sv -----
// subarray_delay_and_sum_core: top level, delay registers, write slot and slot valid bits
// depends on sads_pkg, sads_lane, sads_merge (and sads_ram below the lanes)
//
//  channel   signals                              direction  transfer when
//  input     i_valid o_stall i_item               in         i_valid & !o_stall
//  output    o_valid o_item, i_stall              out        o_valid & !i_stall
//  config    i_cfg_valid o_cfg_ready idx data     in         i_cfg_valid & o_cfg_ready
//
// one item per cycle sustained while o_stall is low; each result passes in order through
// the registered ram read, three-tap sum, multiply by 21845 and queue write
// an 8-entry output queue with in-flight credit lets input keep flowing while output stalls
// reset clears history through per-slot valid bits, no clearing sweep, no startup wait
// config is always ready and takes effect on the next input transfer
`default_nettype none

module subarray_delay_and_sum_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire sads_pkg::t_in_item                i_item,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output sads_pkg::t_out_item                    o_item,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sads_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sads_pkg::DELAY_BITS-1:0]   i_cfg_data
);

    localparam int SB = sads_pkg::SAMPLE_BITS;

    logic [sads_pkg::DELAY_BITS-1:0]    r_delay [sads_pkg::REG_COUNT];
    logic [sads_pkg::SLOT_BITS-1:0]     r_slot;
    logic [sads_pkg::HISTORY_DEPTH-1:0] r_slot_vld;

    logic                                  w_acc;
    logic                                  w_full;
    logic [sads_pkg::MIC_COUNT-1:0][SB-1:0] w_mic;
    sads_pkg::t_lane_ctl                   w_ctl;
    sads_pkg::t_lane_res                   w_res [sads_pkg::SUB_COUNT];

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_full;
    assign w_acc       = i_valid & ~w_full;
    assign w_ctl.acc   = w_acc;
    assign w_ctl.slot  = r_slot;

    assign w_mic[0] = i_item.mic0_sample;
    assign w_mic[1] = i_item.mic1_sample;
    assign w_mic[2] = i_item.mic2_sample;
    assign w_mic[3] = i_item.mic3_sample;
    assign w_mic[4] = i_item.mic4_sample;
    assign w_mic[5] = i_item.mic5_sample;
    assign w_mic[6] = i_item.mic6_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < sads_pkg::REG_COUNT; r++) begin
                r_delay[r] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (sads_pkg::t_reg_idx'(i_cfg_index)) inside
                sads_pkg::REG_SUB1_MID, sads_pkg::REG_SUB1_FAR,
                sads_pkg::REG_SUB2_MID, sads_pkg::REG_SUB2_FAR,
                sads_pkg::REG_SUB3_MID, sads_pkg::REG_SUB3_FAR: begin
                    r_delay[i_cfg_index] <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_slot_vld <= '0;
        end else if (w_acc) begin
            r_slot             <= r_slot + 1'b1;
            r_slot_vld[r_slot] <= 1'b1;
        end
    end

    for (genvar k = 0; k < sads_pkg::SUB_COUNT; k++) begin : g_lane
        sads_pkg::t_tap_samples w_samp;
        sads_pkg::t_tap_delays  w_dly;

        for (genvar t = 0; t < sads_pkg::TAPS; t++) begin : g_tap
            assign w_samp[t] = w_mic[sads_pkg::SUB_MICS[k][t]];
        end

        assign w_dly[0] = '0;
        assign w_dly[1] = r_delay[2*k];
        assign w_dly[2] = r_delay[2*k+1];

        sads_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_slot_vld (r_slot_vld),
            .i_samp     (w_samp),
            .i_delay    (w_dly),
            .o_res      (w_res[k])
        );
    end

    sads_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_full  (w_full),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

// ----- rtl/sads_chk.sv -----
// sads_chk: port-level checks of the subarray delay-and-sum core, bound to the top level
// depends on sads_pkg and subarray_delay_and_sum_core
`default_nettype none

module sads_chk (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                o_stall,
    input  wire logic                o_valid,
    input  wire logic                i_stall,
    input  wire sads_pkg::t_out_item o_item
);

    // held output transfer keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("output payload changed while stalled");

    // reset empties the queue and the in-flight credit
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or input stall after reset");

    // a rise of output valid is checked against an earlier input transfer
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 4))
        else $error("output valid rose without a matching input transfer");

    // input is only held off when results are waiting
    a_stall_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

endmodule

bind subarray_delay_and_sum_core sads_chk u_sads_chk (.*);

`default_nettype wire
